FILE: rtl/cyp_pkg.sv
package cyp_pkg;

	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 20;
	localparam int DZ_W     = 15;
	localparam int YAW_W    = 16;
	localparam int RATE_W   = 19;
	localparam int DRIVE_W  = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	// Shared multiply-accumulate unit: unsigned 16-bit gain times 33-bit signed operand.
	localparam int OPND_W = 33;
	localparam int PROD_W = OPND_W + GAIN_W + 1;
	localparam int INTEG_W = 21;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_KP_ANGLE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_ANGLE    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP_RATE     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KI_RATE     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE     = 4'd7;

	localparam logic [GAIN_W-1:0]  RST_KP_ANGLE    = 16'd1536;
	localparam logic [GAIN_W-1:0]  RST_KI_ANGLE    = 16'd13;
	localparam logic [GAIN_W-1:0]  RST_KP_RATE     = 16'd128;
	localparam logic [GAIN_W-1:0]  RST_KI_RATE     = 16'd9;
	localparam logic [LIMIT_W-1:0] RST_ANGLE_LIMIT = 20'd30000;
	localparam logic [LIMIT_W-1:0] RST_RATE_LIMIT  = 20'd8000;
	localparam logic [DZ_W-1:0]    RST_DEAD_ZONE   = 15'd200;

	localparam logic signed [17:0] HALF_TURN = 18'sd18000;
	localparam logic signed [17:0] FULL_TURN = 18'sd36000;

	localparam logic signed [PROD_W-9:0] DRIVE_HI = 42'sd8388607;
	localparam logic signed [PROD_W-9:0] DRIVE_LO = -42'sd8388608;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp_angle;
		logic [GAIN_W-1:0]  ki_angle;
		logic [GAIN_W-1:0]  kp_rate;
		logic [GAIN_W-1:0]  ki_rate;
		logic [LIMIT_W-1:0] angle_integral_limit;
		logic [LIMIT_W-1:0] rate_integral_limit;
		logic [DZ_W-1:0]    dead_zone;
		logic               reverse_direction;
	} cyp_cfg_t;

	typedef struct packed {
		logic en;
		logic load;
	} mac_ctl_t;

	// Brings an angle within one turn of the range back into [-18000, 18000].
	function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
		logic signed [17:0] r;
		r = a;
		if (a > HALF_TURN) begin
			r = a - FULL_TURN;
		end else if (a < -HALF_TURN) begin
			r = a + FULL_TURN;
		end
		return r;
	endfunction

endpackage

FILE: rtl/cyp_in_if.sv
interface cyp_in_if import cyp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [YAW_W-1:0]  measured_yaw;
	logic signed [RATE_W-1:0] measured_rate;
	logic signed [YAW_W-1:0]  target_yaw;

	modport source (output valid, mode, measured_yaw, measured_rate, target_yaw, input ready);
	modport sink (input valid, mode, measured_yaw, measured_rate, target_yaw, output ready);
endinterface

FILE: rtl/cyp_out_if.sv
interface cyp_out_if import cyp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] turn_drive;
	logic                      drive_saturated;

	modport source (output valid, turn_drive, drive_saturated, input ready);
	modport sink (input valid, turn_drive, drive_saturated, output ready);
endinterface

FILE: rtl/cyp_cfg_if.sv
interface cyp_cfg_if import cyp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/cascaded_yaw_pi_controller_core.sv
// Cascaded yaw PI controller. Each input item carries a measured heading, a measured
// yaw rate and a target heading; it yields exactly one result item with the turn drive
// and a saturation flag. The heading error is wrapped to plus or minus 180 degrees,
// zeroed inside the dead zone and fed to an outer PI stage whose output is the desired
// rate; an inner PI stage acts on the rate error. Both integrals are clamped to their
// configured limits, and a clear item (mode 1) zeroes them and returns a zero drive.
// A control item occupies the block from its acceptance until its result is loaded
// into the output register, and the block is ready again in the cycle after that;
// a clear item goes straight to that last step. The sequencer runs the four gain
// products one after another through a single shared multiplier, with a step of
// its own for each wrap, clamp and subtract. The result sits in an
// output register, so the next item is accepted while it waits to be taken; the
// sequencer only stalls in its last step if the previous result is still unclaimed.
// Configuration writes are always accepted and take effect at once.
module cascaded_yaw_pi_controller_core import cyp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cyp_in_if.sink    meas,
	cyp_out_if.source drive,
	cyp_cfg_if.sink   cfg
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_YAW  = 4'd1;
	localparam logic [3:0] ST_ERR  = 4'd2;
	localparam logic [3:0] ST_DZ   = 4'd3;
	localparam logic [3:0] ST_HI   = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_RERR = 4'd7;
	localparam logic [3:0] ST_RI   = 4'd8;
	localparam logic [3:0] ST_M3   = 4'd9;
	localparam logic [3:0] ST_M4   = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	cyp_cfg_t regs;
	mac_ctl_t mac_ctl;
	logic [GAIN_W-1:0]        mac_gain;
	logic signed [OPND_W-1:0] mac_opnd;
	logic signed [PROD_W-1:0] acc;

	logic [3:0] state_q;

	// Captured item fields; the rate is one bit wider so that it can be negated.
	logic                     clear_q;
	logic signed [YAW_W-1:0]  yaw_q;
	logic signed [RATE_W:0]   rate_q;
	logic signed [YAW_W-1:0]  target_q;

	// Working values of the control step.
	logic signed [YAW_W-1:0]  err_q;
	logic signed [OPND_W-1:0] rerr_q;
	logic signed [INTEG_W-1:0] hi_q;
	logic signed [INTEG_W-1:0] ri_q;

	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic                      out_sat_q;
	logic                      out_load;

	cyp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cyp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.gain    (mac_gain),
		.operand (mac_opnd),
		.acc     (acc)
	);

	assign meas.ready = (state_q == ST_IDLE);
	assign drive.valid = out_valid_q;
	assign drive.turn_drive = out_drive_q;
	assign drive.drive_saturated = out_sat_q;

	// The last step hands its result over once the output register is free or is
	// being emptied in the same cycle.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || drive.ready);

	// Operand and gain selection for the shared multiplier. The first product of each
	// PI stage loads the accumulator and the second one adds to it.
	always_comb begin
		mac_ctl.en   = 1'b0;
		mac_ctl.load = 1'b0;
		mac_gain     = regs.kp_angle;
		mac_opnd     = {{(OPND_W-YAW_W){err_q[YAW_W-1]}}, err_q};
		case (state_q)
			ST_M1: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.load = 1'b1;
			end
			ST_M2: begin
				mac_ctl.en = 1'b1;
				mac_gain   = regs.ki_angle;
				mac_opnd   = {{(OPND_W-INTEG_W){hi_q[INTEG_W-1]}}, hi_q};
			end
			ST_M3: begin
				mac_ctl.en   = 1'b1;
				mac_ctl.load = 1'b1;
				mac_gain     = regs.kp_rate;
				mac_opnd     = rerr_q;
			end
			ST_M4: begin
				mac_ctl.en = 1'b1;
				mac_gain   = regs.ki_rate;
				mac_opnd   = {{(OPND_W-INTEG_W){ri_q[INTEG_W-1]}}, ri_q};
			end
			default: begin
			end
		endcase
	end

	// Step values; each is used only in the state that registers it.
	logic signed [17:0] yaw_sel;
	logic signed [17:0] yaw_wrap;
	logic signed [17:0] err_diff;
	logic signed [17:0] err_wrap;
	logic signed [16:0] dz_ext;
	logic signed [16:0] err_ext;
	logic signed [21:0] hi_sum;
	logic signed [21:0] hi_lim;
	logic signed [OPND_W-1:0] desired;
	logic signed [OPND_W:0]   ri_sum;
	logic signed [OPND_W:0]   ri_lim;
	logic signed [PROD_W-9:0] drv_full;

	always_comb begin
		yaw_sel  = {{2{yaw_q[YAW_W-1]}}, yaw_q};
		if (regs.reverse_direction) begin
			yaw_sel = -yaw_sel;
		end
		yaw_wrap = wrap_angle(yaw_sel);
		err_diff = {{2{target_q[YAW_W-1]}}, target_q} - {{2{yaw_q[YAW_W-1]}}, yaw_q};
		err_wrap = wrap_angle(err_diff);
		dz_ext   = $signed({2'b00, regs.dead_zone});
		err_ext  = {err_q[YAW_W-1], err_q};
		hi_sum   = {hi_q[INTEG_W-1], hi_q} + {{6{err_q[YAW_W-1]}}, err_q};
		hi_lim   = $signed({2'b00, regs.angle_integral_limit});
		// The desired rate always fits well inside the operand width.
		desired  = acc[OPND_W+7:8];
		ri_sum   = {{(OPND_W+1-INTEG_W){ri_q[INTEG_W-1]}}, ri_q} + {rerr_q[OPND_W-1], rerr_q};
		ri_lim   = $signed({{(OPND_W+1-LIMIT_W){1'b0}}, regs.rate_integral_limit});
		// Arithmetic shift right by eight rounds toward minus infinity.
		drv_full = acc[PROD_W-1:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clear_q     <= 1'b0;
			yaw_q       <= '0;
			rate_q      <= '0;
			target_q    <= '0;
			err_q       <= '0;
			rerr_q      <= '0;
			hi_q        <= '0;
			ri_q        <= '0;
			out_valid_q <= 1'b0;
			out_drive_q <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (drive.valid && drive.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (meas.valid) begin
						clear_q  <= meas.mode;
						yaw_q    <= meas.measured_yaw;
						rate_q   <= {meas.measured_rate[RATE_W-1], meas.measured_rate};
						target_q <= meas.target_yaw;
						if (meas.mode) begin
							hi_q    <= '0;
							ri_q    <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_YAW;
						end
					end
				end
				ST_YAW: begin
					yaw_q <= yaw_wrap[YAW_W-1:0];
					if (regs.reverse_direction) begin
						rate_q <= -rate_q;
					end
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= err_wrap[YAW_W-1:0];
					state_q <= ST_DZ;
				end
				ST_DZ: begin
					// Errors strictly inside the dead zone are dropped.
					if (err_ext > -dz_ext && err_ext < dz_ext) begin
						err_q <= '0;
					end
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (hi_sum > hi_lim) begin
						hi_q <= hi_lim[INTEG_W-1:0];
					end else if (hi_sum < -hi_lim) begin
						hi_q <= -hi_lim[INTEG_W-1:0];
					end else begin
						hi_q <= hi_sum[INTEG_W-1:0];
					end
					state_q <= ST_M1;
				end
				ST_M1: begin
					state_q <= ST_M2;
				end
				ST_M2: begin
					state_q <= ST_RERR;
				end
				ST_RERR: begin
					rerr_q  <= desired - {{(OPND_W-RATE_W-1){rate_q[RATE_W]}}, rate_q};
					state_q <= ST_RI;
				end
				ST_RI: begin
					if (ri_sum > ri_lim) begin
						ri_q <= ri_lim[INTEG_W-1:0];
					end else if (ri_sum < -ri_lim) begin
						ri_q <= -ri_lim[INTEG_W-1:0];
					end else begin
						ri_q <= ri_sum[INTEG_W-1:0];
					end
					state_q <= ST_M3;
				end
				ST_M3: begin
					state_q <= ST_M4;
				end
				ST_M4: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Wait here only while the previous result has not been taken.
					if (out_load) begin
						if (clear_q) begin
							out_drive_q <= '0;
							out_sat_q   <= 1'b0;
						end else if (drv_full > DRIVE_HI) begin
							out_drive_q <= DRIVE_HI[DRIVE_W-1:0];
							out_sat_q   <= 1'b1;
						end else if (drv_full < DRIVE_LO) begin
							out_drive_q <= DRIVE_LO[DRIVE_W-1:0];
							out_sat_q   <= 1'b1;
						end else begin
							out_drive_q <= drv_full[DRIVE_W-1:0];
							out_sat_q   <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/cyp_cfg_regs.sv
module cyp_cfg_regs import cyp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cyp_cfg_if.sink  cfg,
	output cyp_cfg_t regs
);

	cyp_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp_angle             <= RST_KP_ANGLE;
			regs_q.ki_angle             <= RST_KI_ANGLE;
			regs_q.kp_rate              <= RST_KP_RATE;
			regs_q.ki_rate              <= RST_KI_RATE;
			regs_q.angle_integral_limit <= RST_ANGLE_LIMIT;
			regs_q.rate_integral_limit  <= RST_RATE_LIMIT;
			regs_q.dead_zone            <= RST_DEAD_ZONE;
			regs_q.reverse_direction    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KP_ANGLE:    regs_q.kp_angle             <= cfg.data[GAIN_W-1:0];
				REG_KI_ANGLE:    regs_q.ki_angle             <= cfg.data[GAIN_W-1:0];
				REG_KP_RATE:     regs_q.kp_rate              <= cfg.data[GAIN_W-1:0];
				REG_KI_RATE:     regs_q.ki_rate              <= cfg.data[GAIN_W-1:0];
				REG_ANGLE_LIMIT: regs_q.angle_integral_limit <= cfg.data[LIMIT_W-1:0];
				REG_RATE_LIMIT:  regs_q.rate_integral_limit  <= cfg.data[LIMIT_W-1:0];
				REG_DEAD_ZONE:   regs_q.dead_zone            <= cfg.data[DZ_W-1:0];
				REG_REVERSE:     regs_q.reverse_direction    <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/cyp_mac.sv
module cyp_mac import cyp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [OPND_W-1:0] operand,
	output logic signed [PROD_W-1:0] acc
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] acc_q;

	// The gain is unsigned, so it enters the signed product with a zero sign bit.
	assign prod = $signed({1'b0, gain}) * operand;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= ctl.load ? prod : acc_q + prod;
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the cascaded yaw PI controller core. A local predictor
// mirrors the two PI stages with their clamped integrals and works out the turn
// drive of every accepted input item. Results are compared in order as they leave
// the block, while both sides of the datapath idle at random in all but the last test.
module testbench;
	import cyp_pkg::*;

	localparam int CLK_HALF_NS    = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRESSURE_HOLD  = 400;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 170;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	// Indexes past the last register; writes to them must leave every setting alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

	localparam logic signed [YAW_W-1:0]  YAW_MIN  = 16'sh8000;
	localparam logic signed [YAW_W-1:0]  YAW_MAX  = 16'sh7fff;
	localparam logic signed [RATE_W-1:0] RATE_MIN = 19'sh40000;
	localparam logic signed [RATE_W-1:0] RATE_MAX = 19'sh3ffff;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] turn_drive;
		logic                      drive_saturated;
	} drive_result_t;

	logic clk;
	logic arst_n;

	cyp_in_if  meas_if ();
	cyp_out_if drive_if ();
	cyp_cfg_if cfg_if ();

	cascaded_yaw_pi_controller_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_if.sink),
		.drive  (drive_if.source),
		.cfg    (cfg_if.sink)
	);

	// Predictor state: the register file as the block should hold it, and both
	// integrals at full precision.
	cyp_cfg_t ctrl_cfg;
	longint   heading_acc;
	longint   rate_acc;

	drive_result_t expected_drives[$];
	int            mismatch_count;
	int            idle_cycles;

	// Knobs for the sender task and the receiver process.
	bit sender_idle_en;
	bit receiver_idle_en;
	int receiver_hold;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	function automatic longint fold_heading(input longint a);
		while (a > 18000) a -= 36000;
		while (a < -18000) a += 36000;
		return a;
	endfunction

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// One control tick of the controller. Clear items wipe both integrals and give a
	// zero drive; update items run the heading loop and then the rate loop.
	function automatic drive_result_t predict_turn_drive(
		input logic                     mode,
		input logic signed [YAW_W-1:0]  yaw_in,
		input logic signed [RATE_W-1:0] rate_in,
		input logic signed [YAW_W-1:0]  target_in
	);
		drive_result_t res;
		longint yaw, rate, err, dz, desired, rate_err, drive_val;
		res = '0;
		if (mode == MODE_CLEAR) begin
			heading_acc = 0;
			rate_acc = 0;
			return res;
		end
		yaw = yaw_in;
		rate = rate_in;
		if (ctrl_cfg.reverse_direction) begin
			yaw = -yaw;
			rate = -rate;
		end
		yaw = fold_heading(yaw);
		err = fold_heading(longint'(target_in) - yaw);
		dz = longint'(ctrl_cfg.dead_zone);
		if (err > -dz && err < dz) err = 0;
		heading_acc = clamp_sym(heading_acc + err, longint'(ctrl_cfg.angle_integral_limit));
		desired = (longint'(ctrl_cfg.kp_angle) * err
			+ longint'(ctrl_cfg.ki_angle) * heading_acc) >>> 8;
		rate_err = desired - rate;
		rate_acc = clamp_sym(rate_acc + rate_err, longint'(ctrl_cfg.rate_integral_limit));
		drive_val = (longint'(ctrl_cfg.kp_rate) * rate_err
			+ longint'(ctrl_cfg.ki_rate) * rate_acc) >>> 8;
		if (drive_val > 64'sd8388607) begin
			drive_val = 64'sd8388607;
			res.drive_saturated = 1'b1;
		end
		if (drive_val < -64'sd8388608) begin
			drive_val = -64'sd8388608;
			res.drive_saturated = 1'b1;
		end
		res.turn_drive = drive_val[DRIVE_W-1:0];
		return res;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_KP_ANGLE:    ctrl_cfg.kp_angle = data[GAIN_W-1:0];
			REG_KI_ANGLE:    ctrl_cfg.ki_angle = data[GAIN_W-1:0];
			REG_KP_RATE:     ctrl_cfg.kp_rate = data[GAIN_W-1:0];
			REG_KI_RATE:     ctrl_cfg.ki_rate = data[GAIN_W-1:0];
			REG_ANGLE_LIMIT: ctrl_cfg.angle_integral_limit = data[LIMIT_W-1:0];
			REG_RATE_LIMIT:  ctrl_cfg.rate_integral_limit = data[LIMIT_W-1:0];
			REG_DEAD_ZONE:   ctrl_cfg.dead_zone = data[DZ_W-1:0];
			REG_REVERSE:     ctrl_cfg.reverse_direction = data[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Register writes happen only while the block is idle, so the predictor can take
	// the new value at the very edge the write is accepted.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = data;
		do @(posedge clk); while (!cfg_if.ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Offers one input item and records its expected result once it is taken. Valid
	// stays high from one item to the next unless an idle burst comes in between.
	task automatic send_meas(
		input logic                     mode,
		input logic signed [YAW_W-1:0]  yaw,
		input logic signed [RATE_W-1:0] rate,
		input logic signed [YAW_W-1:0]  target
	);
		int gap;
		if (sender_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				meas_if.valid = 1'b0;
			end
		end
		@(negedge clk);
		meas_if.valid = 1'b1;
		meas_if.mode = mode;
		meas_if.measured_yaw = yaw;
		meas_if.measured_rate = rate;
		meas_if.target_yaw = target;
		do @(posedge clk); while (!meas_if.ready);
		expected_drives.push_back(predict_turn_drive(mode, yaw, rate, target));
	endtask

	// Lets every outstanding result drain and the sequencer go quiet, so the next
	// register write lands on an idle block.
	task automatic settle_block();
		@(negedge clk);
		meas_if.valid = 1'b0;
		while (expected_drives.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [YAW_W-1:0] pick_heading();
		case ($urandom_range(0, 9))
			0: return YAW_W'($urandom);
			1: return ($urandom_range(0, 1) != 0) ? YAW_MAX : YAW_MIN;
			2: return ($urandom_range(0, 1) != 0) ? 16'sd18000 : -16'sd18000;
			default: return YAW_W'(int'($urandom_range(0, 36000)) - 18000);
		endcase
	endfunction

	function automatic logic signed [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 9))
			0: return RATE_W'($urandom);
			1: return ($urandom_range(0, 1) != 0) ? RATE_MAX : RATE_MIN;
			2, 3: return RATE_W'(int'($urandom_range(0, 400000)) - 200000);
			default: return RATE_W'(int'($urandom_range(0, 4000)) - 2000);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(0, 5))
			0: g = '0;
			1: g = '1;
			2, 3: g = GAIN_W'($urandom_range(0, 1024));
			default: g = GAIN_W'($urandom);
		endcase
		// The upper bits carry noise that the gain registers must drop.
		return {4'($urandom), g};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return CFG_DATA_W'($urandom_range(0, 50000));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dead_zone();
		logic [DZ_W-1:0] dz;
		case ($urandom_range(0, 5))
			0: dz = '0;
			1: dz = 15'd18000;
			2: dz = DZ_W'($urandom);
			default: dz = DZ_W'($urandom_range(0, 2000));
		endcase
		return {5'($urandom), dz};
	endfunction

	// Mostly update items that track a heading near the target, so the dead zone
	// edges and the integral clamps are reached; the rest are clears and wild inputs.
	task automatic send_random_item();
		logic signed [YAW_W-1:0] yaw, target;
		logic mode;
		mode = ($urandom_range(0, 19) == 0) ? MODE_CLEAR : MODE_UPDATE;
		yaw = pick_heading();
		if ($urandom_range(0, 1) != 0) begin
			target = yaw + YAW_W'(int'($urandom_range(0, 1000)) - 500);
		end else begin
			target = pick_heading();
		end
		send_meas(mode, yaw, pick_rate(), target);
	endtask

	// Runs at reset settings, which are never written here, so their reset values
	// are checked too. Covers dead zone edges, exact half turns, out of range
	// headings and the extremes of the rate field.
	task automatic test_reset_settings();
		send_meas(MODE_CLEAR, YAW_MAX, RATE_MAX, YAW_MAX);
		send_meas(MODE_UPDATE, 16'sd0, 19'sd0, 16'sd0);
		send_meas(MODE_UPDATE, 16'sd0, 19'sd0, 16'sd199);
		send_meas(MODE_UPDATE, 16'sd0, 19'sd0, 16'sd200);
		send_meas(MODE_UPDATE, 16'sd0, 19'sd0, -16'sd200);
		send_meas(MODE_UPDATE, 16'sd0, 19'sd0, -16'sd199);
		send_meas(MODE_UPDATE, -16'sd18000, 19'sd0, 16'sd18000);
		send_meas(MODE_UPDATE, 16'sd18000, 19'sd0, -16'sd18000);
		send_meas(MODE_UPDATE, 16'sd17000, 19'sd500, -16'sd17000);
		send_meas(MODE_UPDATE, YAW_MAX, -19'sd1000, YAW_MIN);
		send_meas(MODE_UPDATE, YAW_MIN, 19'sd1000, YAW_MAX);
		send_meas(MODE_UPDATE, 16'sd0, RATE_MAX, 16'sd0);
		send_meas(MODE_UPDATE, 16'sd0, RATE_MIN, 16'sd0);
		settle_block();
	endtask

	// Largest gains and limits drive the output into both rails; then zero limits
	// pin the integrals and a dead zone past a half turn swallows every error.
	task automatic test_extreme_settings();
		write_reg(REG_KP_ANGLE, '1);
		write_reg(REG_KI_ANGLE, '1);
		write_reg(REG_KP_RATE, '1);
		write_reg(REG_KI_RATE, '1);
		write_reg(REG_ANGLE_LIMIT, '1);
		write_reg(REG_RATE_LIMIT, '1);
		write_reg(REG_DEAD_ZONE, '0);
		write_reg(REG_REVERSE, 20'd1);
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, 20'h5a5a5);
		send_meas(MODE_UPDATE, 16'sd0, RATE_MIN, 16'sd0);
		send_meas(MODE_UPDATE, 16'sd0, RATE_MAX, 16'sd0);
		send_meas(MODE_UPDATE, 16'sd18000, 19'sd0, 16'sd0);
		send_meas(MODE_UPDATE, YAW_MIN, RATE_MIN, YAW_MAX);
		send_meas(MODE_CLEAR, 16'sd0, 19'sd0, 16'sd0);
		send_meas(MODE_UPDATE, -16'sd5, 19'sd3, 16'sd7);
		settle_block();
		write_reg(REG_ANGLE_LIMIT, '0);
		write_reg(REG_RATE_LIMIT, '0);
		write_reg(REG_DEAD_ZONE, 20'h07fff);
		write_reg(REG_REVERSE, 20'hffffe);
		send_meas(MODE_UPDATE, 16'sd18000, 19'sd12345, -16'sd1);
		send_meas(MODE_UPDATE, YAW_MIN, RATE_MAX, 16'sd0);
		settle_block();
		write_reg(REG_KP_ANGLE, '0);
		write_reg(REG_KI_RATE, '0);
		write_reg(REG_DEAD_ZONE, 20'd18000);
		send_meas(MODE_UPDATE, -16'sd18000, RATE_MIN, 16'sd17999);
		send_meas(MODE_UPDATE, 16'sd100, -19'sd77, 16'sd18000);
		settle_block();
	endtask

	task automatic write_random_settings();
		write_reg(REG_KP_ANGLE, pick_gain());
		write_reg(REG_KI_ANGLE, pick_gain());
		write_reg(REG_KP_RATE, pick_gain());
		write_reg(REG_KI_RATE, pick_gain());
		write_reg(REG_ANGLE_LIMIT, pick_limit());
		write_reg(REG_RATE_LIMIT, pick_limit());
		write_reg(REG_DEAD_ZONE, pick_dead_zone());
		write_reg(REG_REVERSE, CFG_DATA_W'($urandom));
		write_reg(CFG_IDX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_random_settings();
			repeat (PHASE_ITEMS) send_random_item();
			settle_block();
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// output register and the sequencer both fill and the input stalls.
	task automatic test_output_backpressure();
		write_random_settings();
		receiver_hold = PRESSURE_HOLD;
		repeat (40) send_random_item();
		settle_block();
	endtask

	// Closing stretch with no idling on either side, back to back at full rate.
	task automatic test_full_rate();
		sender_idle_en = 1'b0;
		receiver_idle_en = 1'b0;
		write_random_settings();
		repeat (180) send_random_item();
		settle_block();
	endtask

	// Receiver: random stalls in short bursts, plus the long hold-off on request.
	initial begin
		int burst;
		burst = 0;
		drive_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold > 0) begin
				receiver_hold--;
				drive_if.ready = 1'b0;
			end else if (burst > 0) begin
				burst--;
				drive_if.ready = 1'b0;
			end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 3);
				drive_if.ready = 1'b0;
			end else begin
				drive_if.ready = 1'b1;
			end
		end
	end

	// Checks each result against the oldest expectation.
	always @(posedge clk) begin
		drive_result_t exp_res;
		if (arst_n && drive_if.valid && drive_if.ready) begin
			if (expected_drives.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing pending",
					drive_if.turn_drive));
			end else begin
				exp_res = expected_drives.pop_front();
				if (drive_if.turn_drive !== exp_res.turn_drive) begin
					report_mismatch($sformatf("turn_drive %0d, expected %0d",
						drive_if.turn_drive, exp_res.turn_drive));
				end
				if (drive_if.drive_saturated !== exp_res.drive_saturated) begin
					report_mismatch($sformatf("drive_saturated %0b, expected %0b",
						drive_if.drive_saturated, exp_res.drive_saturated));
				end
			end
		end
	end

	// Ends a run that has stopped moving: no item on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || (meas_if.valid && meas_if.ready) || (drive_if.valid && drive_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("cascaded_yaw_pi_controller_core test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		meas_if.valid = 1'b0;
		meas_if.mode = MODE_UPDATE;
		meas_if.measured_yaw = '0;
		meas_if.measured_rate = '0;
		meas_if.target_yaw = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_KP_ANGLE;
		cfg_if.data = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		receiver_hold = 0;
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;
		heading_acc = 0;
		rate_acc = 0;
		ctrl_cfg.kp_angle = RST_KP_ANGLE;
		ctrl_cfg.ki_angle = RST_KI_ANGLE;
		ctrl_cfg.kp_rate = RST_KP_RATE;
		ctrl_cfg.ki_rate = RST_KI_RATE;
		ctrl_cfg.angle_integral_limit = RST_ANGLE_LIMIT;
		ctrl_cfg.rate_integral_limit = RST_RATE_LIMIT;
		ctrl_cfg.dead_zone = RST_DEAD_ZONE;
		ctrl_cfg.reverse_direction = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_settings();
		test_extreme_settings();
		test_random_phases();
		test_output_backpressure();
		test_full_rate();

		if (mismatch_count == 0) begin
			$display("cascaded_yaw_pi_controller_core test passed");
		end else begin
			$display("cascaded_yaw_pi_controller_core test failed");
		end
		$finish;
	end

endmodule
